// ----- rtl/weekly_schedule_matcher_macros.svh -----
// assertion helpers for the weekly schedule matcher checker
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef WEEKLY_SCHEDULE_MATCHER_MACROS_SVH
`define WEEKLY_SCHEDULE_MATCHER_MACROS_SVH

// same-cycle implication
`define WSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("weekly schedule matcher check failed");

// next-cycle implication
`define WSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("weekly schedule matcher check failed");

`endif

// ----- rtl/wsm_pkg.sv -----
// ----------------------------------------------------------------------------
// wsm_pkg
// Types and constants shared by the weekly schedule matcher files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsm_pkg;

  localparam int REG_SLOTS       = 8;
  localparam int IDX_W           = 3;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 29;
  localparam int MOD_W           = 11;
  localparam int MINUTES_PER_HOUR = 60;

  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;
  localparam logic [2:0] WDAY_NONE  = 3'd7;

  localparam logic [1:0] ACT_ALL_ON  = 2'd0;
  localparam logic [1:0] ACT_ALL_OFF = 2'd1;
  localparam logic [1:0] ACT_PRESET  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [2:0] weekday_now;
    logic       clock_valid;
  } tick_t;

  typedef struct packed {
    logic [1:0] action_code;
    logic [7:0] preset_number;
    logic [2:0] entry_index;
    logic       last_of_run;
  } result_t;

  // register layout of one schedule entry, msb first
  typedef struct packed {
    logic       enable;
    logic [7:0] preset;
    logic [1:0] action;
    logic [6:0] wday_mask;
    logic [5:0] minute;
    logic [4:0] hour;
  } entry_t;

endpackage

// ----- rtl/wsm_if.sv -----
// ----------------------------------------------------------------------------
// wsm_if
// Valid/ready channels of the weekly schedule matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wsm_tick_if;
  logic          valid;
  logic          ready;
  wsm_pkg::tick_t data;
  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

interface wsm_result_if;
  logic            valid;
  logic            ready;
  wsm_pkg::result_t data;
  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

interface wsm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wsm_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [wsm_pkg::CFG_DATA_W-1:0] wdata;
  modport source  (output valid, output reg_index, output wdata, input ready);
  modport sink    (input valid, input reg_index, input wdata, output ready);
  modport monitor (input valid, input reg_index, input wdata, input ready);
endinterface

// ----- rtl/weekly_schedule_matcher.sv -----
// A tick is taken only while idle; entries are then scanned one per cycle through
// a single compare unit, unless a new hit must wait for a free output word, and a
// flush state then hands out the held hit. A held result word stretches the scan;
// no new tick is taken until the flush is done. Ignored ticks are taken without a scan.
// Reset (rst_ni low, async): all entries cleared, no minute handled, idle.
// ----------------------------------------------------------------------------
// weekly_schedule_matcher
// Weekly alarm table: matches time ticks against eight schedule entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weekly_schedule_matcher #(
  parameter int ENTRY_COUNT = 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  wsm_tick_if.sink     tick_i,
  wsm_result_if.source result_o,
  wsm_cfg_if.sink      cfg_i
);
  import wsm_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [IDX_W-1:0]      scan_idx_q, scan_idx_d;
  logic [MOD_W-1:0]      handled_min_q, handled_min_d;
  logic                  handled_vld_q, handled_vld_d;
  logic [CFG_DATA_W-1:0] entry_q [REG_SLOTS];
  logic [CFG_DATA_W-1:0] entry_d [REG_SLOTS];
  logic                  pend_vld_q, pend_vld_d;
  result_t               pend_q, pend_d;
  logic                  out_vld_q, out_vld_d;
  result_t               out_q, out_d;
  logic [4:0]            hour_q, hour_d;
  logic [5:0]            minute_q, minute_d;
  logic [2:0]            wday_q, wday_d;

  entry_t           cur;
  logic [7:0]       day_bit;
  logic             hit;
  logic             out_free;
  logic             tick_acc;
  logic [MOD_W-1:0] tick_mod;

  assign cur      = entry_t'(entry_q[scan_idx_q]);
  assign day_bit  = 8'(1) << wday_q;
  assign hit      = cur.enable && (cur.hour <= MAX_HOUR) && (cur.minute <= MAX_MINUTE)
                 && (cur.hour == hour_q) && (cur.minute == minute_q)
                 && (wday_q != WDAY_NONE) && ((cur.wday_mask & day_bit[6:0]) != 7'd0)
                 && (cur.action != ACT_NONE);
  assign out_free = !out_vld_q || result_o.ready;
  assign tick_acc = tick_i.valid && tick_i.ready;
  assign tick_mod = MOD_W'(MOD_W'(tick_i.data.hour_now) * MOD_W'(MINUTES_PER_HOUR))
                  + MOD_W'(tick_i.data.minute_now);

  assign tick_i.ready    = (state_q == ST_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign result_o.valid  = out_vld_q;
  assign result_o.data   = out_q;

  always_comb begin
    state_d       = state_q;
    scan_idx_d    = scan_idx_q;
    handled_min_d = handled_min_q;
    handled_vld_d = handled_vld_q;
    entry_d       = entry_q;
    pend_vld_d    = pend_vld_q;
    pend_d        = pend_q;
    out_vld_d     = out_vld_q;
    out_d         = out_q;
    hour_d        = hour_q;
    minute_d      = minute_q;
    wday_d        = wday_q;

    if (out_vld_q && result_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (tick_acc && tick_i.data.clock_valid &&
            !(handled_vld_q && (tick_mod == handled_min_q))) begin
          handled_min_d = tick_mod;
          handled_vld_d = 1'b1;
          hour_d        = tick_i.data.hour_now;
          minute_d      = tick_i.data.minute_now;
          wday_d        = tick_i.data.weekday_now;
          scan_idx_d    = '0;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a new hit pushes the held one out, so it waits for a free output word
        if (!(hit && pend_vld_q && !out_free)) begin
          if (hit) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = pend_q;
            end
            pend_vld_d           = 1'b1;
            pend_d.action_code   = cur.action;
            pend_d.preset_number = cur.preset;
            pend_d.entry_index   = scan_idx_q;
            pend_d.last_of_run   = 1'b0;
          end
          if (scan_idx_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            scan_idx_d = scan_idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d         = 1'b1;
          out_d             = pend_q;
          out_d.last_of_run = 1'b1;
          pend_vld_d        = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // writes beyond the table are dropped and keep the handled minute
    if (cfg_i.valid && (cfg_i.reg_index < CFG_IDX_W'(REG_SLOTS))) begin
      entry_d[cfg_i.reg_index[IDX_W-1:0]] = cfg_i.wdata;
      handled_vld_d                       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_idx_q    <= '0;
      handled_min_q <= '0;
      handled_vld_q <= 1'b0;
      pend_vld_q    <= 1'b0;
      out_vld_q     <= 1'b0;
      for (int i = 0; i < REG_SLOTS; i++) begin
        entry_q[i] <= '0;
      end
    end else begin
      state_q       <= state_d;
      scan_idx_q    <= scan_idx_d;
      handled_min_q <= handled_min_d;
      handled_vld_q <= handled_vld_d;
      pend_vld_q    <= pend_vld_d;
      out_vld_q     <= out_vld_d;
      entry_q       <= entry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    out_q    <= out_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    wday_q   <= wday_d;
  end

endmodule

// ----- rtl/wsm_checker.sv -----
// ----------------------------------------------------------------------------
// wsm_checker
// Port-level checks of the weekly schedule matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weekly_schedule_matcher_macros.svh"

module wsm_checker #(
  parameter int ENTRY_COUNT = 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             tick_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input wsm_pkg::result_t res_data_i
);
  import wsm_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  // a stalled result word holds
  `WSM_ASSERT_NEXT(a_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i))

  // while a run is still open no new tick is taken
  `WSM_ASSERT_NOW(a_run_busy, res_valid_i && !res_data_i.last_of_run, !tick_ready_i)

  // only scanned entries can fire
  `WSM_ASSERT_NOW(a_index, res_valid_i, res_data_i.entry_index <= LAST_IDX)

  // the silent action never shows up
  `WSM_ASSERT_NOW(a_action, res_valid_i, res_data_i.action_code != ACT_NONE)

endmodule

bind weekly_schedule_matcher wsm_checker #(.ENTRY_COUNT(ENTRY_COUNT)) u_wsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .tick_ready_i(tick_i.ready),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_data_i  (result_o.data)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weekly schedule matcher. Time ticks go in on a
// valid/ready channel, and the schedule table is loaded through the register
// write channel. A local copy of the table and of the handled minute works
// out the alarm words that each tick must fire. Every word that comes out is
// checked field by field against the oldest word still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wsm_pkg::*;

  localparam int ENTRY_COUNT     = 8;
  localparam int DRAIN_CYCLES    = ENTRY_COUNT + 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int TICKS_PER_PHASE = 18;
  localparam int PHASE_COUNT     = 11;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    tick_t                 t;
    int                    typed_n;   // -1: take the words from the alarm model
    result_t               typed_res;
  } step_t;

  logic clk_i;
  logic rst_ni;

  wsm_tick_if   tick_if ();
  wsm_result_if res_if ();
  wsm_cfg_if    cfg_if ();

  weekly_schedule_matcher #(
    .ENTRY_COUNT(ENTRY_COUNT)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // alarm model state
  entry_t           sched_entry [REG_SLOTS];
  logic [MOD_W-1:0] seen_minute;
  bit               seen_valid;
  result_t          fired_now [$];
  result_t          pending_alarms [$];

  int          send_idle  = 0;
  int          recv_stall = 0;
  int          fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  logic        hold_req;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  function automatic logic [CFG_DATA_W-1:0] pack_entry(bit en, int hr, int mn,
                                                       logic [6:0] mask,
                                                       logic [1:0] act,
                                                       logic [7:0] pre);
    entry_t e;
    e.enable    = en;
    e.hour      = 5'(hr);
    e.minute    = 6'(mn);
    e.wday_mask = mask;
    e.action    = act;
    e.preset    = pre;
    return e;
  endfunction

  function automatic step_t tick_step(int hr, int mn, int wd, bit v, int n,
                                      result_t res);
    step_t s;
    s.is_write      = 1'b0;
    s.reg_idx       = '0;
    s.reg_val       = '0;
    s.t.hour_now    = 5'(hr);
    s.t.minute_now  = 6'(mn);
    s.t.weekday_now = 3'(wd);
    s.t.clock_valid = v;
    s.typed_n       = n;
    s.typed_res     = res;
    return s;
  endfunction

  function automatic step_t write_step(int idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s           = tick_step(0, 0, 0, 1'b0, 0, '0);
    s.is_write  = 1'b1;
    s.reg_idx   = CFG_IDX_W'(idx);
    s.reg_val   = val;
    return s;
  endfunction

  // fills fired_now with the alarm words of one tick, returns 1 when the
  // tick was taken as a new minute
  function automatic bit predict_alarms(tick_t t);
    logic [MOD_W-1:0] mod;
    logic [7:0]       day_bit;
    entry_t           e;
    result_t          r;
    fired_now.delete();
    if (!t.clock_valid) return 1'b0;
    mod = MOD_W'(int'(t.hour_now) * MINUTES_PER_HOUR + int'(t.minute_now));
    if (seen_valid && mod == seen_minute) return 1'b0;
    seen_minute = mod;
    seen_valid  = 1'b1;
    day_bit     = 8'b1 << t.weekday_now;
    for (int i = 0; i < ENTRY_COUNT && i < REG_SLOTS; i++) begin
      e = sched_entry[i];
      if (!e.enable || e.hour > MAX_HOUR || e.minute > MAX_MINUTE) continue;
      if (e.hour != t.hour_now || e.minute != t.minute_now) continue;
      if ((e.wday_mask & day_bit[6:0]) == '0) continue;
      if (e.action == ACT_NONE) continue;
      r.action_code   = e.action;
      r.preset_number = e.preset;
      r.entry_index   = IDX_W'(i);
      r.last_of_run   = 1'b0;
      fired_now = {fired_now, r};
    end
    if (fired_now.size() > 0) fired_now[fired_now.size()-1].last_of_run = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_tick(input tick_t t, input int typed_n, input result_t typed_res,
                           output bit handled);
    cfg_if.valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.data  <= t;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    handled = predict_alarms(t);
    if (typed_n < 0) begin
      pending_alarms = {pending_alarms, fired_now};
    end else if (typed_n == 1) begin
      pending_alarms = {pending_alarms, typed_res};
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (int'(idx) < REG_SLOTS) begin
      sched_entry[idx[IDX_W-1:0]] = entry_t'(val);
      seen_valid                  = 1'b0;
    end
  endtask

  // a tick may still be scanning after its last word, so let it finish
  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    cfg_if.valid  <= 1'b0;
    while (pending_alarms.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : alarm_sink
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  always @(posedge clk_i) begin : alarm_check
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_alarms.size() == 0) begin
        $error("alarm word with none outstanding: entry_index %0d",
               res_if.data.entry_index);
        fail_cnt++;
      end else begin
        want = pending_alarms.pop_front();
        if (res_if.data.action_code !== want.action_code) begin
          $error("action_code: expected %0d, got %0d", want.action_code,
                 res_if.data.action_code);
          fail_cnt++;
        end
        if (res_if.data.preset_number !== want.preset_number) begin
          $error("preset_number: expected %0d, got %0d", want.preset_number,
                 res_if.data.preset_number);
          fail_cnt++;
        end
        if (res_if.data.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index,
                 res_if.data.entry_index);
          fail_cnt++;
        end
        if (res_if.data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                 res_if.data.last_of_run);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    step_t                 plan [$];
    tick_t                 t;
    tick_t                 last_t;
    logic [CFG_DATA_W-1:0] val;
    int                    pool_hour [3];
    int                    pool_min [3];
    int                    handled_cnt;
    int                    sel;
    int                    k;
    bit                    handled;
    bit                    in_burst;

    rst_ni           <= 1'b0;
    hold_req         <= 1'b0;
    tick_if.valid    <= 1'b0;
    tick_if.data     <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= '0;
    cfg_if.wdata     <= '0;
    foreach (sched_entry[i]) sched_entry[i] = '0;
    seen_minute = '0;
    seen_valid  = 1'b0;
    last_t      = '0;
    in_burst    = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // table is empty after reset
    plan = {plan, tick_step(0, 0, 0, 1'b1, 0, '0)};
    plan = {plan, write_step(0, pack_entry(1, 23, 59, 7'h7F, ACT_PRESET, 8'hFF))};
    plan = {plan, write_step(1, pack_entry(1, 0, 0, 7'h01, ACT_ALL_ON, 8'h00))};
    plan = {plan, write_step(2, pack_entry(1, 23, 59, 7'h40, ACT_ALL_OFF, 8'hA5))};
    plan = {plan, write_step(3, pack_entry(1, 23, 59, 7'h7F, ACT_NONE, 8'h3C))};
    plan = {plan, write_step(4, pack_entry(1, 24, 0, 7'h7F, ACT_ALL_ON, 8'h11))};
    plan = {plan, write_step(5, pack_entry(1, 12, 60, 7'h7F, ACT_ALL_OFF, 8'h22))};
    plan = {plan, write_step(6, pack_entry(0, 23, 59, 7'h7F, ACT_PRESET, 8'h33))};
    plan = {plan, write_step(7, pack_entry(1, 0, 0, 7'h7F, ACT_PRESET, 8'h5A))};
    plan = {plan, write_step(8, '1)};
    plan = {plan, write_step(15, '1)};
    plan = {plan, tick_step(23, 59, 6, 1'b1, -1, '0)};
    // same minute again, then on another weekday
    plan = {plan, tick_step(23, 59, 6, 1'b1, 0, '0)};
    plan = {plan, tick_step(23, 59, 3, 1'b1, 0, '0)};
    plan = {plan, tick_step(0, 0, 0, 1'b0, 0, '0)};
    plan = {plan, tick_step(0, 0, 0, 1'b1, -1, '0)};
    plan = {plan, tick_step(23, 59, 5, 1'b1, 1, result_t'{ACT_PRESET, 8'hFF, 3'd0, 1'b1})};
    plan = {plan, tick_step(24, 0, 1, 1'b1, 0, '0)};
    plan = {plan, tick_step(12, 60, 2, 1'b1, 0, '0)};
    plan = {plan, tick_step(31, 63, 7, 1'b1, 0, '0)};
    plan = {plan, tick_step(0, 0, WDAY_NONE, 1'b1, 0, '0)};
    // 0:60 and 1:00 are the same minute of day
    plan = {plan, write_step(1, pack_entry(1, 1, 0, 7'h7F, ACT_ALL_ON, 8'h77))};
    plan = {plan, tick_step(0, 60, 1, 1'b1, 0, '0)};
    plan = {plan, tick_step(1, 0, 1, 1'b1, 0, '0)};
    // out-of-table index keeps the handled minute, a real write clears it
    plan = {plan, write_step(9, pack_entry(1, 1, 0, 7'h7F, ACT_ALL_OFF, 8'h99))};
    plan = {plan, tick_step(1, 0, 1, 1'b1, 0, '0)};
    plan = {plan, write_step(1, pack_entry(1, 1, 0, 7'h7F, ACT_ALL_ON, 8'h77))};
    plan = {plan, tick_step(1, 0, 1, 1'b1, 1, result_t'{ACT_ALL_ON, 8'h77, 3'd1, 1'b1})};
    plan = {plan, tick_step(0, 0, 0, 1'b1, 1, result_t'{ACT_PRESET, 8'h5A, 3'd7, 1'b1})};

    send_idle  = 34;
    recv_stall = 34;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!in_burst) wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_tick(plan[i].t, plan[i].typed_n, plan[i].typed_res, handled);
      end
      in_burst = plan[i].is_write;
    end

    // last phase is the long receiver hold-off
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_idle();
      case (ph % 4)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 83; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 83; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      if (ph == PHASE_COUNT - 1) begin
        send_idle  = 0;
        recv_stall = 0;
      end
      pool_hour[0] = $urandom_range(0, 23);
      pool_min[0]  = $urandom_range(0, 59);
      pool_hour[1] = (ph % 2) ? 23 : 0;
      pool_min[1]  = (ph % 2) ? 59 : 0;
      pool_hour[2] = $urandom_range(0, 23);
      pool_min[2]  = $urandom_range(0, 59);

      for (int i = 0; i < REG_SLOTS; i++) begin
        if (ph == 0 || ph == PHASE_COUNT - 1) begin
          // every entry fires on the same tick
          val = pack_entry(1, pool_hour[0], pool_min[0], 7'h7F,
                           2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
        end else if (ph == 1) begin
          val = '1;
        end else if (ph == 2) begin
          val = '0;
        end else begin
          k   = $urandom_range(0, 2);
          val = pack_entry($urandom_range(0, 7) != 0, pool_hour[k], pool_min[k],
                           7'($urandom_range(0, 127)) | (7'h1 << $urandom_range(0, 6)),
                           2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 9) == 0) begin
            val[4:0]  = 5'($urandom_range(0, 31));
            val[10:5] = 6'($urandom_range(0, 63));
          end
        end
        write_reg(CFG_IDX_W'(i), val);
      end
      write_reg(CFG_IDX_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom));
      if (ph == PHASE_COUNT - 1) hold_req <= 1'b1;

      handled_cnt = 0;
      while (handled_cnt < TICKS_PER_PHASE) begin
        sel              = $urandom_range(0, 99);
        k                = $urandom_range(0, 2);
        t.hour_now       = 5'(pool_hour[k]);
        t.minute_now     = 6'(pool_min[k]);
        t.weekday_now    = 3'($urandom_range(0, 6));
        t.clock_valid    = 1'b1;
        if (sel >= 70 && sel < 80) begin
          t.hour_now    = last_t.hour_now;
          t.minute_now  = last_t.minute_now;
          t.weekday_now = 3'($urandom_range(0, 7));
        end else if (sel >= 80 && sel < 92) begin
          t = tick_t'(15'($urandom));
        end else if (sel >= 92) begin
          t.clock_valid = 1'b0;
        end
        last_t = t;
        send_tick(t, -1, '0, handled);
        handled_cnt += handled;
      end
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
